// File: hw/rtl/pgsc_pkg.sv
// Shared types and constants of the PCM gain, soft clip and mixer block.
package pgsc_pkg;

    localparam logic [1:0] MODE_SILENCE = 2'd0;
    localparam logic [1:0] MODE_PASS    = 2'd1;
    localparam logic [1:0] MODE_PCM     = 2'd2;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_GAIN   = 2'd1;
    localparam logic [1:0] CFG_STEREO = 2'd2;

    localparam logic OP_DIRECT = 1'b0;
    localparam logic OP_PCM    = 1'b1;

    localparam int KNEE_Q15   = 27853;
    localparam int HEAD_Q15   = 4915;
    localparam int GAIN_SHIFT = 12;
    localparam int QUOT_W     = 13;
    localparam logic [15:0] GAIN_RESET = 16'd4096;

    typedef struct packed {
        logic               op;
        logic signed [15:0] first;
        logic signed [15:0] second;
        logic               stereo;
        logic [15:0]        gain;
        logic               last;
        logic [31:0]        underrun;
        logic [31:0]        callback;
    } job_t;

endpackage

// File: hw/rtl/pcm_gain_soft_clip_mixer_core.sv
// Top level of the PCM gain, soft clip and mixer block.
// One request is one stereo frame slot and yields one output frame. Silence and
// passthrough requests go to the output register once it is free; a PCM request
// holds the back end through multiply, prepare, 13-bit soft clip divide and store
// per channel, then finish; both channels share the serial divider, which a
// channel under the knee skips. A two-entry queue lets the front end take requests
// and count underruns and callbacks while the back end works, until it is full.
// Configuration writes are always taken and act from the next request on.
module pcm_gain_soft_clip_mixer_core
    import pgsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] ring_left,
    input  logic signed [15:0] ring_right,
    input  logic               ring_present,
    input  logic signed [15:0] host_first,
    input  logic signed [15:0] host_second,
    input  logic               host_present,
    input  logic               last_slot,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_first,
    output logic signed [15:0] out_second,
    output logic [1:0]         channel_count,
    output logic               frame_last,
    output logic [31:0]        underrun_total,
    output logic [31:0]        callback_total
);

    logic q_full;
    logic q_push;
    job_t q_job;
    logic q_pop;
    logic q_valid;
    job_t q_head;

    pgsc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .ring_left    (ring_left),
        .ring_right   (ring_right),
        .ring_present (ring_present),
        .host_first   (host_first),
        .host_second  (host_second),
        .host_present (host_present),
        .last_slot    (last_slot),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (q_job)
    );

    pgsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head)
    );

    pgsc_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_first      (out_first),
        .out_second     (out_second),
        .channel_count  (channel_count),
        .frame_last     (frame_last),
        .underrun_total (underrun_total),
        .callback_total (callback_total)
    );

endmodule

// File: hw/rtl/pgsc_front.sv
// Front end: configuration registers, request classification and underrun and callback counters.
module pgsc_front
    import pgsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [15:0] ring_left,
    input  logic signed [15:0] ring_right,
    input  logic               ring_present,
    input  logic signed [15:0] host_first,
    input  logic signed [15:0] host_second,
    input  logic               host_present,
    input  logic               last_slot,
    input  logic               q_full,
    output logic               q_push,
    output job_t               q_job
);

    logic [1:0]  mode_reg;
    logic [15:0] gain_reg;
    logic        stereo_reg;
    logic        ring_dry_reg;
    logic        ring_dry_next;
    logic [31:0] underrun_reg;
    logic [31:0] underrun_next;
    logic [31:0] callback_reg;
    logic [31:0] callback_next;
    logic        pcm_live;
    logic        dry_now;
    logic        new_underrun;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign q_push    = in_valid && !q_full;

    always_comb
    begin
        pcm_live      = (mode_reg == MODE_PCM) && (gain_reg != 16'd0);
        new_underrun  = pcm_live && !ring_dry_reg && !ring_present;
        dry_now       = ring_dry_reg || new_underrun;
        underrun_next = underrun_reg + {31'd0, new_underrun};
        callback_next = callback_reg + {31'd0, last_slot};
        ring_dry_next = last_slot ? 1'b0 : dry_now;

        q_job.op       = OP_DIRECT;
        q_job.first    = '0;
        q_job.second   = '0;
        q_job.stereo   = stereo_reg;
        q_job.gain     = gain_reg;
        q_job.last     = last_slot;
        q_job.underrun = underrun_next;
        q_job.callback = callback_next;

        unique case (mode_reg)
            MODE_PASS:
            begin
                if (host_present)
                begin
                    q_job.first  = host_first;
                    q_job.second = stereo_reg ? host_second : 16'sd0;
                end
            end
            MODE_PCM:
            begin
                if (pcm_live && !dry_now)
                begin
                    q_job.op     = OP_PCM;
                    q_job.first  = ring_left;
                    q_job.second = ring_right;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_SILENCE;
            gain_reg     <= GAIN_RESET;
            stereo_reg   <= 1'b1;
            ring_dry_reg <= 1'b0;
            underrun_reg <= '0;
            callback_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_MODE:   mode_reg   <= cfg_data[1:0];
                    CFG_GAIN:   gain_reg   <= cfg_data;
                    CFG_STEREO: stereo_reg <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (q_push)
            begin
                ring_dry_reg <= ring_dry_next;
                underrun_reg <= underrun_next;
                callback_reg <= callback_next;
            end
        end
    end

endmodule

// File: hw/rtl/pgsc_queue.sv
// Two-entry request queue between the front end and the back end.
module pgsc_queue
    import pgsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_job   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/pgsc_back.sv
// Back end: gain, serial soft clip divider, mono mix and output register.
module pgsc_back
    import pgsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  job_t               q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] out_first,
    output logic signed [15:0] out_second,
    output logic [1:0]         channel_count,
    output logic               frame_last,
    output logic [31:0]        underrun_total,
    output logic [31:0]        callback_total
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_STORE = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    job_t               job_reg;
    logic               chan_reg;
    logic [20:0]        a_reg;
    logic               clip_reg;
    logic [33:0]        num_reg;
    logic [33:0]        dvs_reg;
    logic [QUOT_W-1:0]  quot_reg;
    logic [3:0]         cnt_reg;
    logic signed [15:0] res_first_reg;
    logic signed [15:0] res_second_reg;

    logic               out_valid_reg;
    logic signed [15:0] out_first_reg;
    logic signed [15:0] out_second_reg;
    logic               out_stereo_reg;
    logic               out_last_reg;
    logic [31:0]        out_underrun_reg;
    logic [31:0]        out_callback_reg;

    logic               out_free;
    logic signed [15:0] samp;
    logic [16:0]        mag;
    logic [32:0]        prod;
    logic [32:0]        rounded;
    logic [20:0]        d;
    logic [20:0]        den;
    logic [33:0]        hd;
    logic               ge;
    logic [15:0]        clip_sum;
    logic [14:0]        y;
    logic signed [15:0] y_signed;
    logic signed [16:0] mix_sum;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        samp     = chan_reg ? job_reg.second : job_reg.first;
        mag      = samp[15] ? 17'(~{samp[15], samp} + 17'd1) : {1'b0, samp};
        prod     = {16'd0, mag} * {17'd0, job_reg.gain};
        rounded  = prod + 33'(1 << (GAIN_SHIFT - 1));
        d        = a_reg - 21'(KNEE_Q15);
        den      = d + 21'(HEAD_Q15);
        hd       = {13'd0, d} * {21'd0, 13'(HEAD_Q15)};
        ge       = (num_reg >= dvs_reg);
        clip_sum = 16'(KNEE_Q15) + {3'd0, quot_reg};
        if (!clip_reg)
        begin
            y = a_reg[14:0];
        end
        else if (clip_sum > 16'd32767)
        begin
            y = 15'h7FFF;
        end
        else
        begin
            y = clip_sum[14:0];
        end
        y_signed = samp[15] ? -$signed({1'b0, y}) : $signed({1'b0, y});
        mix_sum  = {res_first_reg[15], res_first_reg} + {res_second_reg[15], res_second_reg};
    end

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    if (q_head.op == OP_PCM)
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:   state_next = S_PREP;
            S_PREP:  state_next = (a_reg <= 21'(KNEE_Q15)) ? S_STORE : S_DIV;
            S_DIV:   state_next = (cnt_reg == 4'(QUOT_W - 1)) ? S_STORE : S_DIV;
            S_STORE: state_next = chan_reg ? S_FIN : S_MUL;
            S_FIN:   state_next = out_free ? S_IDLE : S_FIN;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                job_reg  <= q_head;
                chan_reg <= 1'b0;
            end
            S_MUL:
            begin
                a_reg <= rounded[32:GAIN_SHIFT];
            end
            S_PREP:
            begin
                clip_reg <= (a_reg > 21'(KNEE_Q15));
                num_reg  <= hd + {14'd0, den[20:1]};
                dvs_reg  <= {13'd0, den} << (QUOT_W - 1);
                quot_reg <= '0;
                cnt_reg  <= '0;
            end
            S_DIV:
            begin
                if (ge)
                begin
                    num_reg <= num_reg - dvs_reg;
                end
                quot_reg <= {quot_reg[QUOT_W-2:0], ge};
                dvs_reg  <= dvs_reg >> 1;
                cnt_reg  <= cnt_reg + 4'd1;
            end
            S_STORE:
            begin
                if (chan_reg)
                begin
                    res_second_reg <= y_signed;
                end
                else
                begin
                    res_first_reg <= y_signed;
                end
                chan_reg <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_pop)
        begin
            out_first_reg    <= q_head.first;
            out_second_reg   <= q_head.second;
            out_stereo_reg   <= q_head.stereo;
            out_last_reg     <= q_head.last;
            out_underrun_reg <= q_head.underrun;
            out_callback_reg <= q_head.callback;
        end
        else if (state_reg == S_FIN && out_free)
        begin
            out_first_reg    <= job_reg.stereo ? res_first_reg : mix_sum[16:1];
            out_second_reg   <= job_reg.stereo ? res_second_reg : 16'sd0;
            out_stereo_reg   <= job_reg.stereo;
            out_last_reg     <= job_reg.last;
            out_underrun_reg <= job_reg.underrun;
            out_callback_reg <= job_reg.callback;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_IDLE && q_pop && q_head.op == OP_DIRECT)
                || (state_reg == S_FIN && out_free))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_first      = out_first_reg;
    assign out_second     = out_second_reg;
    assign channel_count  = out_stereo_reg ? 2'd2 : 2'd1;
    assign frame_last     = out_last_reg;
    assign underrun_total = out_underrun_reg;
    assign callback_total = out_callback_reg;

endmodule

// File: hw/rtl/pgsc_checker.sv
// Port-level checker of the mixer block and its bind to the top level.
module pgsc_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [15:0] out_first,
    input logic signed [15:0] out_second,
    input logic [1:0]         channel_count,
    input logic [31:0]        callback_total
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_first)
            && $stable(out_second) && $stable(callback_total))
        else $error("stalled output request changed");

    a_count_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> channel_count == 2'd1 || channel_count == 2'd2)
        else $error("bad channel count");

    a_mono_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && channel_count == 2'd1 |-> out_second == 16'sd0)
        else $error("mono output carries a second sample");

    a_stall_known: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid |-> !$isunknown(in_stall) && !$isunknown(out_valid))
        else $error("handshake state unknown while a request waits");

endmodule

bind pcm_gain_soft_clip_mixer_core pgsc_checker u_pgsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_first      (out_first),
    .out_second     (out_second),
    .channel_count  (channel_count),
    .callback_total (callback_total)
);
